// File: rtl/sixfk_pkg.sv
// shared types, constants and link tables for the six-axis forward kinematics block
// no dependencies; imported by the top level, sixfk_front and sixfk_back
package sixfk_pkg;

    localparam int NUM_CFG = 6;

    typedef logic [5:0][31:0] t_six;

    typedef struct packed {
        logic [8:0][31:0] rot;
        logic [2:0][31:0] pos;
    } t_result;

    typedef struct packed {
        logic       valid;
        t_six       item;
    } t_qhead;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PHASE,
        S_XRAD,
        S_XSQ,
        S_TMUL,
        S_TDIV,
        S_TFIX,
        S_SFIN,
        S_STORE,
        S_INIT,
        S_LINK,
        S_PLX,
        S_PLY,
        S_POS,
        S_ROT,
        S_COMMIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [7:0]  div;
        logic [32:0] rcp;
    } t_divstep;

    localparam logic [29:0] TURN_GAIN  = 30'd683565276;
    localparam logic [31:0] QUARTER_PI = 32'd3373259426;
    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam logic [4:0]  LAST_SINE  = 5'd4;
    localparam logic [4:0]  LAST_COS   = 5'd10;

    localparam t_six CFG_RESET = {
        32'd21984864,
        32'd31057982,
        32'd43996571,
        32'hF6DAB9F4,
        32'hF63261DF,
        32'd34171834
    };

    // series divisors with reciprocals floor(2^33 / d)
    function automatic t_divstep div_step(input logic [4:0] n);
        t_divstep r;
        case (n)
            5'd0:    r = '{div: 8'd110, rcp: 33'd78090314};
            5'd1:    r = '{div: 8'd72,  rcp: 33'd119304647};
            5'd2:    r = '{div: 8'd42,  rcp: 33'd204522252};
            5'd3:    r = '{div: 8'd20,  rcp: 33'd429496729};
            5'd4:    r = '{div: 8'd6,   rcp: 33'd1431655765};
            5'd5:    r = '{div: 8'd132, rcp: 33'd65075262};
            5'd6:    r = '{div: 8'd90,  rcp: 33'd95443717};
            5'd7:    r = '{div: 8'd56,  rcp: 33'd153391689};
            5'd8:    r = '{div: 8'd30,  rcp: 33'd286331153};
            5'd9:    r = '{div: 8'd12,  rcp: 33'd715827882};
            5'd10:   r = '{div: 8'd2,   rcp: 33'd4294967296};
            default: r = '{div: 8'd1,   rcp: 33'd0};
        endcase
        return r;
    endfunction

endpackage

// File: rtl/six_axis_forward_kinematics.sv
// top level of the six-axis forward kinematics block: ports, link offset registers
// depends on sixfk_pkg, sixfk_front, sixfk_back (which holds sixfk_mul)
//
// channel   handshake            payload
// ------    ---------            -------
// joints    start / busy         i_angle_base .. i_angle_wrist_three, Q4.28 rad
// pose      o_valid (strobe)     o_rot_00 .. o_rot_22 Q2.30, o_pos_x/y/z Q4.28 m
// config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// a beat is taken when start is high and busy low; busy rises only when the queue is full
// each pose is paced by the single shared 34x34 multiplier: a pop from the queue, then the six
// sine/cosine pairs, then the link chain, then a finish step
// o_valid is high for one cycle per pose and the receiver cannot stall
// synchronous active-low reset empties the queue and loads the default link offsets
module six_axis_forward_kinematics #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_angle_base,
    input  logic signed [31:0] i_angle_shoulder,
    input  logic signed [31:0] i_angle_elbow,
    input  logic signed [31:0] i_angle_wrist_one,
    input  logic signed [31:0] i_angle_wrist_two,
    input  logic signed [31:0] i_angle_wrist_three,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_rot_00,
    output logic signed [31:0] o_rot_01,
    output logic signed [31:0] o_rot_02,
    output logic signed [31:0] o_rot_10,
    output logic signed [31:0] o_rot_11,
    output logic signed [31:0] o_rot_12,
    output logic signed [31:0] o_rot_20,
    output logic signed [31:0] o_rot_21,
    output logic signed [31:0] o_rot_22,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z
);
    import sixfk_pkg::*;

    t_six     r_cfg;
    t_six     item;
    t_qhead   head;
    logic     pop;
    t_result  res;

    assign item = {i_angle_wrist_three, i_angle_wrist_two, i_angle_wrist_one,
                   i_angle_elbow, i_angle_shoulder, i_angle_base};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we && (32'(i_cfg_idx) < NUM_CFG)) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    sixfk_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (item),
        .o_busy  (busy),
        .o_head  (head),
        .i_pop   (pop)
    );

    sixfk_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .i_cfg   (r_cfg),
        .o_done  (o_valid),
        .o_res   (res)
    );

    assign o_rot_00 = res.rot[0];
    assign o_rot_01 = res.rot[1];
    assign o_rot_02 = res.rot[2];
    assign o_rot_10 = res.rot[3];
    assign o_rot_11 = res.rot[4];
    assign o_rot_12 = res.rot[5];
    assign o_rot_20 = res.rot[6];
    assign o_rot_21 = res.rot[7];
    assign o_rot_22 = res.rot[8];
    assign o_pos_x  = res.pos[0];
    assign o_pos_y  = res.pos[1];
    assign o_pos_z  = res.pos[2];
endmodule

// File: rtl/sixfk_mul.sv
// shared signed 34x34 multiplier with registered product
// imports nothing from sixfk_pkg; no submodules
module sixfk_mul (
    input  logic               i_clk,
    input  logic signed [33:0] i_a,
    input  logic signed [33:0] i_b,
    output logic signed [67:0] o_p
);
    logic signed [67:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// File: rtl/sixfk_front.sv
// front end: accepts joint beats and holds them in a short queue
// depends on sixfk_pkg
module sixfk_front #(
    parameter int DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  sixfk_pkg::t_six        i_item,
    output logic                   o_busy,
    output sixfk_pkg::t_qhead      o_head,
    input  logic                   i_pop
);
    import sixfk_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_six             r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             full, push, pop;

    assign full   = (r_cnt == (AW+1)'(DEPTH));
    assign push   = i_start & ~full;
    assign pop    = i_pop & (r_cnt != '0);
    assign o_busy = full;
    assign o_head = '{valid: (r_cnt != '0), item: r_mem[r_rp]};

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// File: rtl/sixfk_back.sv
// back end: sequencer that evaluates sine, cosine and the link chain on one shared multiplier
// depends on sixfk_pkg and sixfk_mul
module sixfk_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sixfk_pkg::t_qhead     i_head,
    output logic                  o_pop,
    input  sixfk_pkg::t_six       i_cfg,
    output logic                  o_done,
    output sixfk_pkg::t_result    o_res
);
    import sixfk_pkg::*;

    t_state              r_state, n_state;
    logic                r_ph;
    t_six                r_ang;
    logic [2:0]          r_j;
    logic [4:0]          r_n;
    logic [2:0]          r_oct;
    logic [29:0]         r_g;
    logic [29:0]         r_x;
    logic [30:0]         r_x2, r_num, r_q0, r_t, r_s;
    logic signed [31:0]  r_sn [6];
    logic signed [31:0]  r_cs [6];
    logic signed [31:0]  r_rot [9];
    logic signed [31:0]  r_nr [9];
    logic signed [39:0]  r_p [3];
    logic signed [32:0]  r_pl [3];
    logic signed [63:0]  r_acc;
    logic [1:0]          r_i, r_k, r_col;
    logic                r_done;
    t_result             r_res;

    logic signed [33:0]  mul_a, mul_b;
    logic signed [67:0]  prod;
    logic signed [63:0]  prod64, acc_sum, acc_rnd, pl_sum;
    logic [31:0]         phase;
    logic [61:0]         xsum, usum;
    logic [31:0]         sv;
    logic [39:0]         qd1;
    logic [30:0]         q_fix;
    logic [3:0]          ridx, nidx;
    logic signed [31:0]  lr, sval, cval, dsel;
    logic signed [31:0]  cfg_l;
    t_divstep            ds;
    logic                last_k;

    function automatic logic signed [31:0] link_rot(
        input logic [2:0] l,
        input logic [1:0] row,
        input logic [1:0] col,
        input logic signed [31:0] s,
        input logic signed [31:0] c
    );
        logic signed [31:0] one;
        logic signed [31:0] v;
        one = $signed({1'b0, ONE_Q30});
        v = '0;
        case (l)
            3'd0, 3'd3: begin
                case ({row, col})
                    4'b0000: v = c;
                    4'b0010: v = s;
                    4'b0100: v = s;
                    4'b0110: v = -c;
                    4'b1001: v = one;
                    default: v = '0;
                endcase
            end
            3'd4: begin
                case ({row, col})
                    4'b0000: v = c;
                    4'b0010: v = -s;
                    4'b0100: v = s;
                    4'b0110: v = c;
                    4'b1001: v = -one;
                    default: v = '0;
                endcase
            end
            default: begin
                case ({row, col})
                    4'b0000: v = c;
                    4'b0001: v = -s;
                    4'b0100: v = s;
                    4'b0101: v = c;
                    4'b1010: v = one;
                    default: v = '0;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] hold_unit(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd1073741824) begin
            r = 32'sd1073741824;
        end else if (v < -64'sd1073741824) begin
            r = -32'sd1073741824;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    sixfk_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign prod64  = prod[63:0];
    assign ridx    = {2'b00, r_i} * 4'd3 + {2'b00, r_k};
    assign nidx    = {2'b00, r_i} * 4'd3 + {2'b00, r_col};
    assign lr      = link_rot(r_j, r_k, r_col, r_sn[r_j], r_cs[r_j]);
    assign ds      = div_step(r_n);
    assign cfg_l   = (r_j == 3'd1) ? $signed(i_cfg[1]) : $signed(i_cfg[2]);
    assign last_k  = (r_k == 2'd2);
    assign acc_sum = r_acc + prod64;
    assign acc_rnd = (acc_sum + 64'sd536870912) >>> 30;
    assign pl_sum  = (prod64 + 64'sd536870912) >>> 30;
    assign phase   = prod[59:28];
    assign xsum    = prod[61:0] + 62'd1073741824;
    assign usum    = prod[61:0] + 62'd536870912;
    assign sv      = usum[61:30];
    assign qd1     = (40'(r_q0) + 40'd1) * 40'(ds.div);
    assign q_fix   = (40'(r_num) >= qd1) ? r_q0 + 31'd1 : r_q0;
    assign sval    = $signed({1'b0, r_s});
    assign cval    = $signed({1'b0, r_t});

    always_comb begin
        case (r_j)
            3'd3:    dsel = $signed(i_cfg[3]);
            3'd4:    dsel = $signed(i_cfg[4]);
            default: dsel = $signed(i_cfg[5]);
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_head.valid) n_state = S_PHASE;
            S_PHASE:  if (r_ph) n_state = S_XRAD;
            S_XRAD:   if (r_ph) n_state = S_XSQ;
            S_XSQ:    if (r_ph) n_state = S_TDIV;
            S_TMUL:   if (r_ph) n_state = S_TDIV;
            S_TDIV:   if (r_ph) n_state = S_TFIX;
            S_TFIX: begin
                if (r_ph) begin
                    if (r_n == LAST_SINE) n_state = S_SFIN;
                    else if (r_n == LAST_COS) n_state = S_STORE;
                    else n_state = S_TMUL;
                end
            end
            S_SFIN:   if (r_ph) n_state = S_TDIV;
            S_STORE:  if (r_ph) n_state = (r_j == 3'd5) ? S_INIT : S_PHASE;
            S_INIT:   if (r_ph) n_state = S_LINK;
            S_LINK:   if (r_ph) n_state = (r_j == 3'd1 || r_j == 3'd2) ? S_PLX : S_POS;
            S_PLX:    if (r_ph) n_state = S_PLY;
            S_PLY:    if (r_ph) n_state = S_POS;
            S_POS:    if (r_ph && last_k && r_i == 2'd2) n_state = S_ROT;
            S_ROT:    if (r_ph && last_k && r_col == 2'd2 && r_i == 2'd2) n_state = S_COMMIT;
            S_COMMIT: if (r_ph) n_state = (r_j == 3'd5) ? S_DONE : S_LINK;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // multiplier operands and queue pop
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        o_pop = (r_state == S_IDLE) && i_head.valid;
        case (r_state)
            S_PHASE: begin
                mul_a = 34'($signed(r_ang[r_j]));
                mul_b = $signed({4'b0, TURN_GAIN});
            end
            S_XRAD: begin
                mul_a = $signed({4'b0, r_g});
                mul_b = $signed({2'b0, QUARTER_PI});
            end
            S_XSQ: begin
                mul_a = $signed({4'b0, r_x});
                mul_b = $signed({4'b0, r_x});
            end
            S_TMUL: begin
                mul_a = $signed({3'b0, r_x2});
                mul_b = $signed({3'b0, r_t});
            end
            S_TDIV: begin
                mul_a = $signed({3'b0, r_num});
                mul_b = $signed({1'b0, ds.rcp});
            end
            S_SFIN: begin
                mul_a = $signed({4'b0, r_x});
                mul_b = $signed({3'b0, r_t});
            end
            S_PLX: begin
                mul_a = 34'(cfg_l);
                mul_b = 34'(r_cs[r_j]);
            end
            S_PLY: begin
                mul_a = 34'(cfg_l);
                mul_b = 34'(r_sn[r_j]);
            end
            S_POS: begin
                mul_a = 34'(r_rot[ridx]);
                mul_b = 34'(r_pl[r_k]);
            end
            S_ROT: begin
                mul_a = 34'(r_rot[ridx]);
                mul_b = 34'(lr);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= (r_state == S_IDLE || r_state == S_DONE) ? 1'b0 : ~r_ph;
            r_done  <= (r_state == S_DONE);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    r_ang <= i_head.item;
                    r_j   <= '0;
                end
            end
            S_PHASE: begin
                if (r_ph) begin
                    r_oct <= phase[31:29];
                    r_g   <= phase[29] ? 30'd536870912 - {1'b0, phase[28:0]}
                                       : {1'b0, phase[28:0]};
                end
            end
            S_XRAD: if (r_ph) r_x <= xsum[60:31];
            S_XSQ: begin
                if (r_ph) begin
                    r_x2  <= usum[60:30];
                    r_num <= usum[60:30];
                    r_n   <= '0;
                end
            end
            S_TMUL:  if (r_ph) r_num <= usum[60:30];
            S_TDIV:  if (r_ph) r_q0 <= prod[63:33];
            S_TFIX: begin
                if (r_ph) begin
                    r_t <= ONE_Q30 - q_fix;
                    if (r_n != LAST_SINE && r_n != LAST_COS) r_n <= r_n + 5'd1;
                end
            end
            S_SFIN: begin
                if (r_ph) begin
                    r_s   <= (sv > {1'b0, ONE_Q30}) ? ONE_Q30 : sv[30:0];
                    r_n   <= LAST_SINE + 5'd1;
                    r_num <= r_x2;
                end
            end
            S_STORE: begin
                if (r_ph) begin
                    case (r_oct)
                        3'd0: begin r_sn[r_j] <= sval;  r_cs[r_j] <= cval;  end
                        3'd1: begin r_sn[r_j] <= cval;  r_cs[r_j] <= sval;  end
                        3'd2: begin r_sn[r_j] <= cval;  r_cs[r_j] <= -sval; end
                        3'd3: begin r_sn[r_j] <= sval;  r_cs[r_j] <= -cval; end
                        3'd4: begin r_sn[r_j] <= -sval; r_cs[r_j] <= -cval; end
                        3'd5: begin r_sn[r_j] <= -cval; r_cs[r_j] <= -sval; end
                        3'd6: begin r_sn[r_j] <= -cval; r_cs[r_j] <= sval;  end
                        default: begin r_sn[r_j] <= -sval; r_cs[r_j] <= cval; end
                    endcase
                    r_j <= (r_j == 3'd5) ? 3'd0 : r_j + 3'd1;
                end
            end
            S_INIT: begin
                if (r_ph) begin
                    for (int e = 0; e < 9; e++) begin
                        r_rot[e] <= link_rot(3'd0, 2'(e / 3), 2'(e % 3), r_sn[0], r_cs[0]);
                    end
                    r_p[0] <= '0;
                    r_p[1] <= '0;
                    r_p[2] <= 40'($signed(i_cfg[0]));
                    r_j    <= 3'd1;
                end
            end
            S_LINK: begin
                if (r_ph) begin
                    r_acc <= '0;
                    r_i   <= '0;
                    r_k   <= '0;
                    r_col <= '0;
                    if (!(r_j == 3'd1 || r_j == 3'd2)) begin
                        r_pl[0] <= '0;
                        r_pl[1] <= '0;
                        r_pl[2] <= 33'(dsel);
                    end
                end
            end
            S_PLX: if (r_ph) r_pl[0] <= pl_sum[32:0];
            S_PLY: begin
                if (r_ph) begin
                    r_pl[1] <= pl_sum[32:0];
                    r_pl[2] <= '0;
                end
            end
            S_POS: begin
                if (r_ph) begin
                    if (last_k) begin
                        r_p[r_i] <= r_p[r_i] + acc_rnd[39:0];
                        r_acc    <= '0;
                        r_k      <= '0;
                        r_i      <= (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
                    end else begin
                        r_acc <= acc_sum;
                        r_k   <= r_k + 2'd1;
                    end
                end
            end
            S_ROT: begin
                if (r_ph) begin
                    if (last_k) begin
                        r_nr[nidx] <= hold_unit(acc_rnd);
                        r_acc      <= '0;
                        r_k        <= '0;
                        if (r_col == 2'd2) begin
                            r_col <= '0;
                            r_i   <= r_i + 2'd1;
                        end else begin
                            r_col <= r_col + 2'd1;
                        end
                    end else begin
                        r_acc <= acc_sum;
                        r_k   <= r_k + 2'd1;
                    end
                end
            end
            S_COMMIT: begin
                if (r_ph) begin
                    for (int e = 0; e < 9; e++) begin
                        r_rot[e] <= r_nr[e];
                    end
                    if (r_j != 3'd5) r_j <= r_j + 3'd1;
                end
            end
            S_DONE: begin
                for (int e = 0; e < 9; e++) begin
                    r_res.rot[e] <= r_rot[e];
                end
                for (int e = 0; e < 3; e++) begin
                    if (r_p[e] > 40'sd2147483647) begin
                        r_res.pos[e] <= 32'h7FFFFFFF;
                    end else if (r_p[e] < -40'sd2147483648) begin
                        r_res.pos[e] <= 32'h80000000;
                    end else begin
                        r_res.pos[e] <= r_p[e][31:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

// File: bench/six_axis_forward_kinematics_test.sv
// self-checking bench for six_axis_forward_kinematics: directed pose table, then random poses
// over several link offset settings; depends on sixfk_pkg and the rtl under rtl/
module six_axis_forward_kinematics_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sixfk_pkg::*;

    typedef logic [11:0][31:0] t_pose;

    typedef struct {
        t_six  ang;
        bit    typed;
        t_pose want;
    } t_pose_row;

    localparam int REG_BASE_HEIGHT  = 0;
    localparam int REG_UPPER_ARM    = 1;
    localparam int REG_FOREARM      = 2;
    localparam int REG_WRIST_ONE    = 3;
    localparam int REG_WRIST_TWO    = 4;
    localparam int REG_TOOL_FLANGE  = 5;
    localparam int REG_UNUSED_LO    = 6;
    localparam int REG_UNUSED_HI    = 7;
    localparam int STALL_LIMIT      = 20000;
    localparam longint UNIT         = 64'sd1073741824;
    localparam longint HALF_PI_Q28  = 64'sd421657428;
    localparam longint PI_Q28       = 64'sd843314857;
    localparam longint TWO_PI_Q28   = 64'sd1686629713;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_six        angles = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_valid;
    logic signed [31:0] o_rot_00, o_rot_01, o_rot_02, o_rot_10, o_rot_11, o_rot_12;
    logic signed [31:0] o_rot_20, o_rot_21, o_rot_22, o_pos_x, o_pos_y, o_pos_z;

    six_axis_forward_kinematics DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_angle_base(angles[0]), .i_angle_shoulder(angles[1]), .i_angle_elbow(angles[2]),
        .i_angle_wrist_one(angles[3]), .i_angle_wrist_two(angles[4]),
        .i_angle_wrist_three(angles[5]),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .o_rot_00(o_rot_00), .o_rot_01(o_rot_01), .o_rot_02(o_rot_02),
        .o_rot_10(o_rot_10), .o_rot_11(o_rot_11), .o_rot_12(o_rot_12),
        .o_rot_20(o_rot_20), .o_rot_21(o_rot_21), .o_rot_22(o_rot_22),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [31:0] link_regs [6];
    t_pose       pending_poses [$];
    int          fail_count = 0;
    int          stall_cycles = 0;
    bit          in_reset = 1'b1;
    longint      frame_rot [9];
    longint      frame_pos [3];
    longint      link_rot [9];
    longint      link_pos [3];
    string       field_name [12] = '{"rot_00", "rot_01", "rot_02", "rot_10", "rot_11",
        "rot_12", "rot_20", "rot_21", "rot_22", "pos_x", "pos_y", "pos_z"};

    function automatic longint rnd(longint p, int n);
        return (p + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > UNIT) return UNIT;
        if (v < -UNIT) return -UNIT;
        return v;
    endfunction

    function automatic void joint_sin_cos(longint a, output longint sn, output longint cs);
        longint prod, g, x, x2, t, u, s, c;
        logic [31:0] phase;
        logic [2:0] oct;
        prod = a * 64'sd683565276;
        phase = prod[59:28];
        oct = phase[31:29];
        g = oct[0] ? (64'sd536870912 - longint'(phase[28:0])) : longint'(phase[28:0]);
        x = (g * 64'sd3373259426 + (64'sd1 <<< 30)) >>> 31;
        x2 = rnd(x * x, 30);
        t = UNIT - x2 / 110;
        t = UNIT - rnd(x2 * t, 30) / 72;
        t = UNIT - rnd(x2 * t, 30) / 42;
        t = UNIT - rnd(x2 * t, 30) / 20;
        t = UNIT - rnd(x2 * t, 30) / 6;
        s = clamp_unit(rnd(x * t, 30));
        u = UNIT - x2 / 132;
        u = UNIT - rnd(x2 * u, 30) / 90;
        u = UNIT - rnd(x2 * u, 30) / 56;
        u = UNIT - rnd(x2 * u, 30) / 30;
        u = UNIT - rnd(x2 * u, 30) / 12;
        u = UNIT - rnd(x2 * u, 30) / 2;
        c = clamp_unit(u);
        case (oct)
            3'd0: begin sn = s;  cs = c;  end
            3'd1: begin sn = c;  cs = s;  end
            3'd2: begin sn = c;  cs = -s; end
            3'd3: begin sn = s;  cs = -c; end
            3'd4: begin sn = -s; cs = -c; end
            3'd5: begin sn = -c; cs = -s; end
            3'd6: begin sn = -c; cs = s;  end
            default: begin sn = -s; cs = c; end
        endcase
    endfunction

    function automatic void set_link(longint a, longint b, longint c, longint d, longint e,
                                     longint f, longint g, longint h, longint k,
                                     longint px, longint py, longint pz);
        link_rot = '{a, b, c, d, e, f, g, h, k};
        link_pos = '{px, py, pz};
    endfunction

    function automatic void chain_link();
        longint nr [9];
        longint acc;
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += frame_rot[i*3+k] * link_pos[k];
            frame_pos[i] += rnd(acc, 30);
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += frame_rot[i*3+k] * link_rot[k*3+j];
                nr[i*3+j] = clamp_unit(rnd(acc, 30));
            end
        end
        frame_rot = nr;
    endfunction

    function automatic t_pose tool_pose(t_six ang);
        longint sn [6];
        longint cs [6];
        longint d [6];
        t_pose res;
        for (int i = 0; i < 6; i++) begin
            joint_sin_cos(longint'($signed(ang[i])), sn[i], cs[i]);
            d[i] = longint'($signed(link_regs[i]));
        end
        frame_rot = '{cs[0], 0, sn[0], sn[0], 0, -cs[0], 0, UNIT, 0};
        frame_pos = '{0, 0, d[REG_BASE_HEIGHT]};
        set_link(cs[1], -sn[1], 0, sn[1], cs[1], 0, 0, 0, UNIT,
                 rnd(d[REG_UPPER_ARM] * cs[1], 30), rnd(d[REG_UPPER_ARM] * sn[1], 30), 0);
        chain_link();
        set_link(cs[2], -sn[2], 0, sn[2], cs[2], 0, 0, 0, UNIT,
                 rnd(d[REG_FOREARM] * cs[2], 30), rnd(d[REG_FOREARM] * sn[2], 30), 0);
        chain_link();
        set_link(cs[3], 0, sn[3], sn[3], 0, -cs[3], 0, UNIT, 0, 0, 0, d[REG_WRIST_ONE]);
        chain_link();
        set_link(cs[4], 0, -sn[4], sn[4], 0, cs[4], 0, -UNIT, 0, 0, 0, d[REG_WRIST_TWO]);
        chain_link();
        set_link(cs[5], -sn[5], 0, sn[5], cs[5], 0, 0, 0, UNIT, 0, 0, d[REG_TOOL_FLANGE]);
        chain_link();
        for (int i = 0; i < 9; i++) res[i] = frame_rot[i][31:0];
        for (int i = 0; i < 3; i++) begin
            if (frame_pos[i] > 64'sd2147483647) res[9+i] = 32'h7FFFFFFF;
            else if (frame_pos[i] < -64'sd2147483648) res[9+i] = 32'h80000000;
            else res[9+i] = frame_pos[i][31:0];
        end
        return res;
    endfunction

    // pose result checker and stall watchdog
    always @(posedge i_clk) begin
        t_pose got, want;
        if (!in_reset) begin
            if ((start && !busy) || o_valid) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("six_axis_forward_kinematics test failed");
                $finish;
            end
        end
        if (!in_reset && o_valid) begin
            got = {o_pos_z, o_pos_y, o_pos_x, o_rot_22, o_rot_21, o_rot_20,
                   o_rot_12, o_rot_11, o_rot_10, o_rot_02, o_rot_01, o_rot_00};
            if (pending_poses.size() == 0) begin
                $display("%0t: pose beat with none pending", $time);
                fail_count++;
            end else begin
                want = pending_poses.pop_front();
                for (int i = 0; i < 12; i++)
                    if (got[i] !== want[i]) begin
                        $display("%0t: %s expected %0d actual %0d", $time, field_name[i],
                                 $signed(want[i]), $signed(got[i]));
                        fail_count++;
                    end
            end
        end
    end

    task automatic send_pose(t_pose_row row, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        angles <= row.ang;
        do @(posedge i_clk); while (busy);
        pending_poses.push_back(row.typed ? row.want : tool_pose(row.ang));
    endtask

    task automatic write_reg(int idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx[2:0];
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx < 6) link_regs[idx] = val;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_six all_joints(longint v);
        t_six a;
        for (int i = 0; i < 6; i++) a[i] = v[31:0];
        return a;
    endfunction

    function automatic t_six random_joints();
        t_six a;
        for (int i = 0; i < 6; i++)
            if ($urandom_range(3) == 0) a[i] = $urandom;
            else a[i] = 32'($urandom_range(2 * TWO_PI_Q28)) - 32'(TWO_PI_Q28);
        return a;
    endfunction

    initial begin
        t_pose_row table_rows [$];
        t_pose_row row;
        t_pose zero_pose;
        logic [31:0] setting;
        int idle_pct;
        for (int i = 0; i < 6; i++) link_regs[i] = CFG_RESET[i];
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        in_reset = 1'b0;
        @(posedge i_clk);

        // all joints at zero with reset offsets
        zero_pose = '0;
        zero_pose[0] = UNIT[31:0];
        zero_pose[5] = -UNIT[31:0];
        zero_pose[7] = UNIT[31:0];
        zero_pose[9] = -32'sd317908013;
        zero_pose[10] = -32'sd65981435;
        zero_pose[11] = 32'sd3113852;
        table_rows.push_back('{all_joints(0), 1'b1, zero_pose});
        table_rows.push_back('{all_joints(64'sh7FFFFFFF), 1'b0, '0});
        table_rows.push_back('{all_joints(-64'sh80000000), 1'b0, '0});
        table_rows.push_back('{all_joints(-1), 1'b0, '0});
        table_rows.push_back('{all_joints(1), 1'b0, '0});
        table_rows.push_back('{all_joints(HALF_PI_Q28), 1'b0, '0});
        table_rows.push_back('{all_joints(PI_Q28), 1'b0, '0});
        table_rows.push_back('{all_joints(-PI_Q28), 1'b0, '0});
        table_rows.push_back('{all_joints(TWO_PI_Q28), 1'b0, '0});
        table_rows.push_back('{all_joints(HALF_PI_Q28 / 2), 1'b0, '0});
        table_rows.push_back('{all_joints(3 * HALF_PI_Q28 / 2), 1'b0, '0});
        table_rows.push_back('{all_joints(-HALF_PI_Q28 / 2), 1'b0, '0});
        table_rows.push_back('{all_joints(64'sh55555555), 1'b0, '0});
        table_rows.push_back('{all_joints(64'shAAAAAAAA), 1'b0, '0});
        for (int i = 0; i < 6; i++) begin
            row.ang = '0;
            row.ang[i] = HALF_PI_Q28[31:0];
            row.typed = 1'b0;
            table_rows.push_back(row);
        end
        foreach (table_rows[i]) send_pose(table_rows[i], 0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            for (int r = REG_BASE_HEIGHT; r <= REG_UNUSED_HI; r++) begin
                case (phase)
                    0: setting = (r < REG_UNUSED_LO) ? CFG_RESET[r] : $urandom;
                    1: setting = 32'h7FFFFFFF;
                    2: setting = 32'h80000000;
                    4: setting = '0;
                    default: setting = $urandom;
                endcase
                write_reg(r, setting);
            end
            i_cfg_we <= 1'b0;
            idle_pct = (phase < 2) ? 24 : (phase < 4) ? 79 : 0;
            repeat (300) begin
                row.ang = random_joints();
                row.typed = 1'b0;
                send_pose(row, idle_pct);
            end
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (fail_count == 0) $display("six_axis_forward_kinematics test passed");
        else $display("six_axis_forward_kinematics test failed");
        $finish;
    end
endmodule

// File: six_axis_forward_kinematics.f
rtl/sixfk_pkg.sv
rtl/sixfk_mul.sv
rtl/sixfk_front.sv
rtl/sixfk_back.sv
rtl/six_axis_forward_kinematics.sv
bench/six_axis_forward_kinematics_test.sv
